/* src/fpd_pkg.sv */
// Shared constants for the signed 16.16 fixed-point divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

	localparam int WORD_W       = 32;
	localparam int FRAC_BITS_DEF = 16;

endpackage

`default_nettype wire

/* src/fixed_point_divide_16_16_core.sv */
// Signed fixed-point divider core: restoring division pipelined one quotient bit a stage.
// Depends on fpd_pkg.
//
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     dividend, divisor
// out      output     out_valid / out_ready   quotient
//
// One word enters per cycle unless out_valid waits on out_ready; its quotient passes through
// one entry stage, one compare-subtract stage per dividend bit, and one zero-divisor and
// sign-fix output stage. The whole pipeline holds while out_valid waits on out_ready.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_divide_16_16_core #(
	parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [fpd_pkg::WORD_W-1:0] dividend,
	input  wire logic signed [fpd_pkg::WORD_W-1:0] divisor,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [fpd_pkg::WORD_W-1:0]      quotient
);
	import fpd_pkg::*;

	localparam int NUM_W = WORD_W + FRAC_BITS;

	typedef struct packed {
		logic              neg;
		logic              zero;
		logic [NUM_W-1:0]  dvd;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] den;
		logic [WORD_W-1:0] quo;
	} stage_t;

	stage_t                    div_s [0:NUM_W];
	logic                      vld_s [0:NUM_W];
	logic                      vld_out_s;
	logic [WORD_W-1:0]         quo_out_s;
	logic                      advance;
	logic [WORD_W-1:0]         mag_num;
	logic [WORD_W-1:0]         mag_den;

	assign advance   = !vld_out_s || out_ready;
	assign in_ready  = advance;
	assign out_valid = vld_out_s;
	assign quotient  = quo_out_s;

	assign mag_num = dividend[WORD_W-1] ? (WORD_W'(0) - WORD_W'(dividend)) : WORD_W'(dividend);
	assign mag_den = divisor[WORD_W-1]  ? (WORD_W'(0) - WORD_W'(divisor))  : WORD_W'(divisor);

	// entry stage: magnitudes and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			div_s[0].neg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			div_s[0].zero <= (divisor == '0);
			div_s[0].dvd  <= {mag_num, {FRAC_BITS{1'b0}}};
			div_s[0].rem  <= '0;
			div_s[0].den  <= mag_den;
			div_s[0].quo  <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < NUM_W; k++) begin : g_bit
		logic [WORD_W:0]   shifted;
		logic [WORD_W:0]   diff;
		stage_t            nxt;

		always_comb begin
			shifted  = {div_s[k].rem, div_s[k].dvd[NUM_W-1]};
			diff     = shifted - {1'b0, div_s[k].den};
			nxt      = div_s[k];
			nxt.dvd  = {div_s[k].dvd[NUM_W-2:0], 1'b0};
			nxt.rem  = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
			nxt.quo  = {div_s[k].quo[WORD_W-2:0], ~diff[WORD_W]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (advance) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	// output stage: zero divisor and sign fix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_s <= 1'b0;
		end else if (advance) begin
			vld_out_s <= vld_s[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			priority if (div_s[NUM_W].zero) begin
				quo_out_s <= '0;
			end else if (div_s[NUM_W].neg) begin
				quo_out_s <= WORD_W'(0) - div_s[NUM_W].quo;
			end else begin
				quo_out_s <= div_s[NUM_W].quo;
			end
		end
	end

endmodule

`default_nettype wire

/* dv/tb_fixed_point_divide_16_16_core.sv */
// Testbench for the signed 16.16 fixed-point divider core: random and directed operand words
// checked in order against a built-in quotient predictor. Depends on fpd_pkg and the core.
`timescale 1ns / 1ps

module tb_fixed_point_divide_16_16_core;

	localparam int W    = fpd_pkg::WORD_W;
	localparam int FRAC = fpd_pkg::FRAC_BITS_DEF;

	typedef logic signed [W-1:0] word_t;

	localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam word_t MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam word_t ONE      = word_t'(1) << FRAC;
	localparam word_t HALF     = word_t'(1) << (FRAC - 1);

	function automatic word_t fixed_quotient(word_t num, word_t den);
		logic [W-1:0]     mag_num;
		logic [W-1:0]     mag_den;
		logic [2*W-1:0]   wide;
		logic [W-1:0]     q;
		if (den == '0) begin
			return '0;
		end
		mag_num = num[W-1] ? -num : num;
		mag_den = den[W-1] ? -den : den;
		wide = ({{W{1'b0}}, mag_num} << FRAC) / {{W{1'b0}}, mag_den};
		q = wide[W-1:0];
		if (num[W-1] ^ den[W-1]) begin
			q = -q;
		end
		return word_t'(q);
	endfunction

	class quotient_board;
		word_t pending_quotients[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		function void note_operands(word_t num, word_t den);
			pending_quotients.push_back(fixed_quotient(num, den));
		endfunction

		function void check_quotient(word_t actual);
			word_t expected;
			if (pending_quotients.size() == 0) begin
				$display("%0t: unexpected quotient %h", $time, actual);
				errors++;
				return;
			end
			expected = pending_quotients.pop_front();
			if (actual !== expected) begin
				$display("%0t: quotient mismatch, expected %h, actual %h", $time, expected, actual);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_quotients.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	word_t dividend = '0;
	word_t divisor = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t quotient;

	int send_idle = 0;
	int recv_stall = 0;

	quotient_board board = new();

	fixed_point_divide_16_16_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.quotient  (quotient)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#6ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) begin
			board.check_quotient(quotient);
		end
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_word(word_t num, word_t den);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		dividend <= num;
		divisor  <= den;
		do @(posedge clk); while (!in_ready);
		board.note_operands(num, den);
	endtask

	function automatic word_t pick_operand();
		word_t v;
		word_t corners[8];
		corners = '{'0, word_t'(1), -word_t'(1), MOST_NEG, MOST_POS, ONE, -ONE, HALF};
		v = word_t'($urandom);
		case ($urandom_range(7))
			0, 1, 2: ;
			3, 4, 5: begin
				v = word_t'($urandom >> $urandom_range(31));
				if ($urandom_range(1)) v = -v;
			end
			6: v = corners[$urandom_range(7)];
			default: begin
				v = word_t'($urandom_range(65535));
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_word(pick_operand(), pick_operand());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		send_word('0, word_t'(1));
		send_word(word_t'(1), '0);
		send_word(MOST_NEG, '0);
		send_word(MOST_POS, MOST_POS);
		send_word(MOST_NEG, MOST_NEG);
		send_word(MOST_NEG, word_t'(1));
		send_word(MOST_NEG, -word_t'(1));
		send_word(MOST_POS, word_t'(1));
		send_word(MOST_POS, MOST_NEG);
		send_word(word_t'(1), MOST_POS);
		send_word(HALF, ONE);
		send_word(ONE, 3 * ONE);
		send_word(-ONE, 3 * ONE);
		send_word(ONE, -3 * ONE);
		send_word(-HALF, word_t'(1));
		send_word(HALF, word_t'(1));
		send_word(-word_t'(1), -word_t'(1));
		send_word(5 * ONE, -2 * ONE);
		send_word(word_t'(32'h1234_5678), word_t'(32'hfedc_ba98));

		run_random(320);
		send_idle = 85;
		run_random(310);
		send_idle = 0;
		recv_stall = 85;
		run_random(310);
		send_idle = 28;
		recv_stall = 28;
		run_random(310);

		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* fixed_point_divide_16_16_core.f */
src/fpd_pkg.sv
src/fixed_point_divide_16_16_core.sv
dv/tb_fixed_point_divide_16_16_core.sv
